// ----- rtl/lsmf_pkg.sv -----
// Package with shared constants and types for the line substring match finder.
package lsmf_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned CFG_W     = 64;
    localparam int unsigned PLEN_W    = 5;
    localparam int unsigned PAT_BYTES = 16;
    localparam int unsigned RES_W     = 32;

    localparam logic [BYTE_W-1:0] NEWLINE = 8'd10;

    typedef enum logic [1:0] {
        CFG_PATTERN_FIRST = 2'd0,
        CFG_PATTERN_LAST  = 2'd1,
        CFG_PATTERN_LEN   = 2'd2
    } cfg_index_t;

    typedef logic [BYTE_W-1:0] byte_t;

endpackage

// ----- rtl/line_substring_match_finder.sv -----
// Top level of the line substring match finder: byte stream in, matching lines out.
//
// The block scans a text buffer one byte per transaction on the s_ channel and
// reports every line that contains the configured pattern (1 to MAX_PATTERN
// bytes, zero length disables matching) as one transaction on the m_ channel:
// the line's byte offset and its length without the newline. A line is
// reported when its newline arrives or when the byte flagged by s_tlast arrives;
// s_tlast also returns the offset to zero for the next buffer. The window
// compare and the offset counters update in the cycle the byte is accepted,
// and the result lands in a single output register that is refilled in the
// same cycle it is drained, so one byte per cycle is sustained while m_tready
// stays high. Configuration writes apply from the next byte on.
module line_substring_match_finder #(
    parameter int unsigned MAX_PATTERN  = 16,
    parameter int unsigned OFFSET_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_wdata,
    // input byte stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte[7:0]
    input  logic        s_tlast,   // last_byte
    // matching lines
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata    // line_offset[31:0], line_length[63:32]
);

    localparam int unsigned FILL_W = $clog2(MAX_PATTERN + 1);
    localparam int unsigned OW     = OFFSET_WIDTH;

    logic [lsmf_pkg::CFG_W-1:0]  pattern_first_reg;
    logic [lsmf_pkg::CFG_W-1:0]  pattern_last_reg;
    logic [lsmf_pkg::PLEN_W-1:0] pattern_len_reg;

    lsmf_pkg::byte_t window_reg  [MAX_PATTERN];
    lsmf_pkg::byte_t window_next [MAX_PATTERN];
    lsmf_pkg::byte_t pattern     [lsmf_pkg::PAT_BYTES];

    logic [OW-1:0]     byte_position_reg, byte_position_next;
    logic [OW-1:0]     line_begin_reg, line_begin_next;
    logic [FILL_W-1:0] line_fill_reg, line_fill_next;
    logic              line_hit_reg, line_hit_next;

    logic              m_valid_reg;
    logic [lsmf_pkg::RES_W-1:0] offset_reg, length_reg;

    logic              in_accept;
    logic              is_newline;
    logic              window_hit;
    logic              out_load;
    logic [OW-1:0]     pos_inc;
    logic [OW-1:0]     line_stop;
    logic [OW-1:0]     line_len;
    logic [MAX_PATTERN-1:0] len_match;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_first_reg <= '0;
            pattern_last_reg  <= '0;
            pattern_len_reg   <= '0;
        end else if (cfg_we) begin
            unique case (lsmf_pkg::cfg_index_t'(cfg_index))
                lsmf_pkg::CFG_PATTERN_FIRST: pattern_first_reg <= cfg_wdata;
                lsmf_pkg::CFG_PATTERN_LAST:  pattern_last_reg  <= cfg_wdata;
                lsmf_pkg::CFG_PATTERN_LEN:
                    pattern_len_reg <= cfg_wdata[lsmf_pkg::PLEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            pattern[i]     = pattern_first_reg[8*i +: 8];
            pattern[i + 8] = pattern_last_reg[8*i +: 8];
        end
    end

    assign s_tready   = !m_valid_reg || m_tready;
    assign in_accept  = s_tvalid && s_tready;
    assign is_newline = (s_tdata == lsmf_pkg::NEWLINE);
    assign pos_inc    = byte_position_reg + OW'(1);

    // Window shifts only on bytes that belong to the line.
    always_comb begin
        window_next[0] = s_tdata;
        for (int k = 1; k < MAX_PATTERN; k++) begin
            window_next[k] = window_reg[k-1];
        end
    end

    always_comb begin
        if (line_fill_reg < FILL_W'(MAX_PATTERN)) begin
            line_fill_next = line_fill_reg + FILL_W'(1);
        end else begin
            line_fill_next = line_fill_reg;
        end
    end

    // For each candidate length, compare the newest bytes against the pattern head.
    always_comb begin
        for (int l = 1; l <= MAX_PATTERN; l++) begin
            len_match[l-1] = 1'b1;
            for (int i = 0; i < l; i++) begin
                if (window_next[l-1-i] != pattern[i]) begin
                    len_match[l-1] = 1'b0;
                end
            end
        end
    end

    always_comb begin
        window_hit = 1'b0;
        for (int l = 1; l <= MAX_PATTERN; l++) begin
            if (pattern_len_reg == lsmf_pkg::PLEN_W'(l)
                    && 32'(line_fill_next) >= 32'(l)) begin
                window_hit = len_match[l-1];
            end
        end
    end

    always_comb begin
        line_hit_next      = line_hit_reg;
        line_begin_next    = line_begin_reg;
        byte_position_next = pos_inc;
        if (is_newline) begin
            line_stop = byte_position_reg;
        end else begin
            line_stop = pos_inc;
            if (window_hit) begin
                line_hit_next = 1'b1;
            end
        end
        line_len = line_stop - line_begin_reg;
        out_load = in_accept && (is_newline || s_tlast) && line_hit_next;
        if (s_tlast) begin
            byte_position_next = '0;
            line_begin_next    = '0;
            line_hit_next      = 1'b0;
        end else if (is_newline) begin
            line_begin_next    = pos_inc;
            line_hit_next      = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_position_reg <= '0;
            line_begin_reg    <= '0;
            line_fill_reg     <= '0;
            line_hit_reg      <= 1'b0;
            for (int k = 0; k < MAX_PATTERN; k++) begin
                window_reg[k] <= '0;
            end
        end else if (in_accept) begin
            byte_position_reg <= byte_position_next;
            line_begin_reg    <= line_begin_next;
            line_hit_reg      <= line_hit_next;
            if (s_tlast || is_newline) begin
                line_fill_reg <= '0;
            end else begin
                line_fill_reg <= line_fill_next;
            end
            if (!is_newline) begin
                for (int k = 0; k < MAX_PATTERN; k++) begin
                    window_reg[k] <= window_next[k];
                end
            end
        end
    end

    // Output register; it is reloaded in the same cycle its transaction completes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            offset_reg <= lsmf_pkg::RES_W'(64'(line_begin_reg));
            length_reg <= lsmf_pkg::RES_W'(64'(line_len));
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {length_reg, offset_reg};

`ifndef ASSERT_OFF
    property p_fill_bounded;
        @(posedge aclk) disable iff (!aresetn)
        line_fill_reg <= FILL_W'(MAX_PATTERN);
    endproperty
    a_fill_bounded: assert property (p_fill_bounded)
        else $error("line fill count exceeds window depth");

    property p_last_clears;
        @(posedge aclk) disable iff (!aresetn)
        (in_accept && s_tlast) |=> (byte_position_reg == '0 && line_begin_reg == '0
                                    && !line_hit_reg && line_fill_reg == '0);
    endproperty
    a_last_clears: assert property (p_last_clears)
        else $error("line state not cleared after final byte");

    property p_result_at_line_end;
        @(posedge aclk) disable iff (!aresetn)
        out_load |-> (is_newline || s_tlast);
    endproperty
    a_result_at_line_end: assert property (p_result_at_line_end)
        else $error("result produced in the middle of a line");

    property p_no_overrun;
        @(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_tready) |-> !in_accept;
    endproperty
    a_no_overrun: assert property (p_no_overrun)
        else $error("byte accepted while a stalled result would be overwritten");
`endif

endmodule
